// ===== rtl/core/cpmm_pkg.sv =====
// shared types and constants of the cartridge page mirror map unit
package cpmm_pkg;

	// configuration port geometry
	localparam int unsigned REG_ADDR_W = 5;
	localparam int unsigned DATA_W     = 32;

	// widest window position before reduction: start offset plus page offset
	localparam int unsigned POS_W      = 25;
	localparam int unsigned OFFSET_W   = 24;

	// register indexes, byte address is 4*index
	typedef enum logic [2:0] {
		REG_MAP_MODE     = 3'd0,
		REG_BANK_FIRST   = 3'd1,
		REG_BANK_LAST    = 3'd2,
		REG_PAGE_FIRST   = 3'd3,
		REG_PAGE_LAST    = 3'd4,
		REG_TARGET_KIND  = 3'd5,
		REG_START_OFFSET = 3'd6,
		REG_TARGET_SIZE  = 3'd7
	} reg_idx_t;

	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_SHADOW = 1'b1;

	typedef struct packed {
		logic        map_mode;
		logic [7:0]  bank_first;
		logic [7:0]  bank_last;
		logic [7:0]  page_first;
		logic [7:0]  page_last;
		logic        target_kind;
		logic [23:0] start_offset;
		logic [24:0] target_size;
	} cfg_t;

	typedef struct packed {
		logic [7:0] bank;
		logic [7:0] page;
	} in_word_t;

	typedef struct packed {
		logic        hit;
		logic        mem_kind;
		logic [23:0] page_offset;
	} out_word_t;

endpackage

// ===== rtl/core/cartridge_page_mirror_map_unit.sv =====
// top level of the cartridge page mirror map unit
// Maps a bus (bank, page) word onto the byte offset of that page's start
// in cartridge ROM or save RAM for one mapping window set over the APB
// port. A hit passes through these states: S_MUL forms the page offset
// (one small multiply in linear mode), S_SUM adds the start offset and
// launches the remainder unit, and S_DIV waits while the shift-subtract
// remainder unit reduces the 25-bit window position modulo the target
// size; S_FIN then hands the result into the output register once that
// register is free. A miss or a zero target size skips the arithmetic
// and goes straight from acceptance to S_FIN. One word is worked on at
// a time and in_stall is high while it is; the result sits in an output
// register, so a new word is taken while a finished one waits on
// out_stall. Because the reduced position is already below the target
// size, the non-power-of-two mirror fold leaves it unchanged and needs
// no extra steps. A target size above 2^SIZE_BITS is clamped to
// 2^SIZE_BITS. The user must write configuration only while the unit
// is idle; the block itself does not enforce this.
module cartridge_page_mirror_map_unit #(
	parameter int unsigned SIZE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// apb configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cpmm_pkg::REG_ADDR_W-1:0]   paddr,
	input  logic [cpmm_pkg::DATA_W-1:0]       pwdata,
	output logic [cpmm_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// input word channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  cpmm_pkg::in_word_t                in_data,
	// result word channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output cpmm_pkg::out_word_t               out_data
);

	localparam int unsigned SW = SIZE_BITS + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_SUM  = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                 state_q;
	cpmm_pkg::cfg_t         cfg;

	// captured word and working values
	logic [7:0]             bank_q;
	logic [7:0]             page_q;
	logic                   hit_q;
	logic                   kind_q;
	logic [23:0]            off_q;
	logic [23:0]            res_q;
	logic                   out_valid_q;
	cpmm_pkg::out_word_t    out_q;

	logic                   hit_c;
	logic                   accept;
	logic                   out_free;
	logic [32:0]            tsz_ext;
	logic [32:0]            size_lim;
	logic [32:0]            size_wide;
	logic [SW-1:0]          size_c;
	logic [7:0]             bdiff;
	logic [7:0]             pdiff;
	logic [8:0]             per_bank;
	logic [16:0]            bank_pages;
	logic [15:0]            count_c;
	logic [cpmm_pkg::POS_W-1:0] pos_c;
	logic                   rem_start;
	logic                   rem_done;
	logic [SW-1:0]          rem_val;

	cpmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// target size clamped to 2^SIZE_BITS
	assign tsz_ext   = 33'(cfg.target_size);
	assign size_lim  = 33'(1) << SIZE_BITS;
	assign size_wide = (tsz_ext > size_lim) ? size_lim : tsz_ext;
	assign size_c    = SW'(size_wide);

	// window check on the incoming word, empty windows never hit
	assign hit_c = (in_data.bank >= cfg.bank_first) && (in_data.bank <= cfg.bank_last) &&
	               (in_data.page >= cfg.page_first) && (in_data.page <= cfg.page_last);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// page offset within the window, both values stay non-negative on a hit
	assign bdiff      = bank_q - cfg.bank_first;
	assign pdiff      = page_q - cfg.page_first;
	assign per_bank   = {1'b0, cfg.page_last} - {1'b0, cfg.page_first} + 9'd1;
	assign bank_pages = bdiff * per_bank;
	assign count_c    = 16'(bank_pages) + 16'(pdiff);

	// window position before reduction
	assign pos_c     = cpmm_pkg::POS_W'(cfg.start_offset) + cpmm_pkg::POS_W'(off_q);
	assign rem_start = (state_q == S_SUM);

	cpmm_rem_unit #(
		.SIZE_BITS (SIZE_BITS)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (pos_c),
		.divisor   (size_c),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (hit_c && size_c != '0)
							state_q <= S_MUL;
						else
							state_q <= S_FIN;
					end
				end
				S_MUL:  state_q <= S_SUM;
				S_SUM:  state_q <= S_DIV;
				S_DIV: begin
					if (rem_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bank_q <= in_data.bank;
			page_q <= in_data.page;
			hit_q  <= hit_c;
			kind_q <= hit_c && cfg.target_kind;
			res_q  <= '0;
		end
		if (state_q == S_MUL) begin
			// shadow: full 64k banks plus page*256, linear: consecutive pages
			if (cfg.map_mode == cpmm_pkg::MODE_SHADOW)
				off_q <= {bdiff, page_q, 8'd0};
			else
				off_q <= {count_c, 8'd0};
		end
		if (state_q == S_DIV && rem_done)
			res_q <= 24'(rem_val);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_q.hit         <= hit_q;
			out_q.mem_kind    <= kind_q;
			out_q.page_offset <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/cpmm_regs.sv =====
// apb configuration register file of the page mirror map unit
module cpmm_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cpmm_pkg::REG_ADDR_W-1:0]      paddr,
	input  logic [cpmm_pkg::DATA_W-1:0]          pwdata,
	output logic [cpmm_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	output cpmm_pkg::cfg_t                       cfg
);

	cpmm_pkg::cfg_t   cfg_q;
	cpmm_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = cpmm_pkg::reg_idx_t'(paddr[cpmm_pkg::REG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_mode     <= 1'b0;
			cfg_q.bank_first   <= 8'd0;
			cfg_q.bank_last    <= 8'd0;
			cfg_q.page_first   <= 8'd0;
			cfg_q.page_last    <= 8'd255;
			cfg_q.target_kind  <= 1'b0;
			cfg_q.start_offset <= 24'd0;
			cfg_q.target_size  <= 25'd0;
		end else if (wr_en) begin
			unique case (idx)
				cpmm_pkg::REG_MAP_MODE:     cfg_q.map_mode     <= pwdata[0];
				cpmm_pkg::REG_BANK_FIRST:   cfg_q.bank_first   <= pwdata[7:0];
				cpmm_pkg::REG_BANK_LAST:    cfg_q.bank_last    <= pwdata[7:0];
				cpmm_pkg::REG_PAGE_FIRST:   cfg_q.page_first   <= pwdata[7:0];
				cpmm_pkg::REG_PAGE_LAST:    cfg_q.page_last    <= pwdata[7:0];
				cpmm_pkg::REG_TARGET_KIND:  cfg_q.target_kind  <= pwdata[0];
				cpmm_pkg::REG_START_OFFSET: cfg_q.start_offset <= pwdata[23:0];
				cpmm_pkg::REG_TARGET_SIZE:  cfg_q.target_size  <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			cpmm_pkg::REG_MAP_MODE:     prdata = 32'(cfg_q.map_mode);
			cpmm_pkg::REG_BANK_FIRST:   prdata = 32'(cfg_q.bank_first);
			cpmm_pkg::REG_BANK_LAST:    prdata = 32'(cfg_q.bank_last);
			cpmm_pkg::REG_PAGE_FIRST:   prdata = 32'(cfg_q.page_first);
			cpmm_pkg::REG_PAGE_LAST:    prdata = 32'(cfg_q.page_last);
			cpmm_pkg::REG_TARGET_KIND:  prdata = 32'(cfg_q.target_kind);
			cpmm_pkg::REG_START_OFFSET: prdata = 32'(cfg_q.start_offset);
			cpmm_pkg::REG_TARGET_SIZE:  prdata = 32'(cfg_q.target_size);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/cpmm_rem_unit.sv =====
// iterative shift-subtract remainder unit, one dividend bit per cycle
module cpmm_rem_unit #(
	parameter int unsigned SIZE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cpmm_pkg::POS_W-1:0]    dividend,
	input  logic [SIZE_BITS:0]            divisor,
	output logic                          done,
	output logic [SIZE_BITS:0]            remainder
);

	localparam int unsigned SW = SIZE_BITS + 1;
	localparam int unsigned PW = cpmm_pkg::POS_W;
	localparam int unsigned CW = $clog2(PW + 1);

	logic [PW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [SW:0]   trial;
	logic [SW:0]   diff;
	logic          ge;

	// shared subtract and compare
	assign trial = {rem_q, quo_q[PW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	assign done      = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[PW-2:0], 1'b0};
			rem_q <= ge ? SW'(diff) : SW'(trial);
		end
	end

endmodule

// ===== rtl/core/cpmm_checker.sv =====
// port-level checker of the page mirror map unit and its bind
module cpmm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input cpmm_pkg::in_word_t   in_data,
	input logic                 out_valid,
	input logic                 out_stall,
	input cpmm_pkg::out_word_t  out_data
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// a miss carries no kind and no offset
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> !out_data.mem_kind && out_data.page_offset == '0)
		else $error("miss word with nonzero fields");

	// an accepted word keeps the unit busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("unit not busy after taking a word");

	// a new result only appears while a word is in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without work in progress");

endmodule

bind cartridge_page_mirror_map_unit cpmm_checker u_cpmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the cartridge page mirror map unit
module tb;

	localparam int unsigned MAP_SIZE_BITS = 24;
	// target sizes above this are clamped to it
	localparam logic [63:0] SIZE_CAP = 64'd1 << MAP_SIZE_BITS;
	localparam int unsigned PHASES = 12;
	localparam int unsigned TAIL_WORDS = 60;
	localparam int unsigned MAX_REPORTS = 10;

	localparam cpmm_pkg::out_word_t MISS_WORD = '0;
	localparam cpmm_pkg::out_word_t ROM_ZERO = {1'b1, 1'b0, 24'h000000};

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	// one line of the directed script: either a register write or a bus word
	typedef struct packed {
		row_kind_t           kind;
		cpmm_pkg::reg_idx_t  idx;
		logic [31:0]         value;
		cpmm_pkg::in_word_t  word;
		logic                typed;
		cpmm_pkg::out_word_t map;
	} dir_row_t;

	// a bus word in flight and the mapping it should produce
	typedef struct packed {
		cpmm_pkg::in_word_t  word;
		cpmm_pkg::out_word_t map;
	} pending_map_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [cpmm_pkg::REG_ADDR_W-1:0] paddr = '0;
	logic [cpmm_pkg::DATA_W-1:0] pwdata = '0;
	logic [cpmm_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	cpmm_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	cpmm_pkg::out_word_t out_data;

	// testbench copy of the mapping window registers
	cpmm_pkg::cfg_t window_cfg;
	dir_row_t dir_rows[$];
	pending_map_t expected_maps[$];
	int unsigned mismatch_count = 0;
	int unsigned result_count = 0;
	int unsigned stall_left = 0;
	pending_map_t head;
	// idling controls: calm phases have no gaps on that side, the tail has none at all
	logic quiet_tail = 1'b0;
	logic sender_calm = 1'b0;
	logic sink_calm = 1'b0;

	always #4 clk = ~clk;

	cartridge_page_mirror_map_unit #(
		.SIZE_BITS(MAP_SIZE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// non-power-of-two mirror fold: strip the top set bit until the position is in range
	function automatic logic [63:0] mirror_fold(logic [63:0] span, logic [63:0] addr);
		logic [63:0] base;
		logic [63:0] top;
		base = '0;
		while (span != 0 && addr >= span) begin
			top = 64'h8000_0000;
			while (top != 0 && (addr & top) == 0)
				top = top >> 1;
			if (top == 0)
				break;
			if (span <= top) begin
				addr = addr - top;
			end else begin
				base = base + top;
				span = span - top;
				addr = addr - top;
			end
		end
		return (span == 0) ? base : base + addr;
	endfunction

	// page start offset of one bus word under a given window setting
	function automatic cpmm_pkg::out_word_t map_page(cpmm_pkg::cfg_t c,
			cpmm_pkg::in_word_t w);
		logic [63:0] span;
		logic [63:0] pos;
		logic [63:0] per_bank;
		logic [63:0] count;
		cpmm_pkg::out_word_t r;
		r = MISS_WORD;
		span = 64'(c.target_size);
		if (span > SIZE_CAP)
			span = SIZE_CAP;
		// outside the window (or an empty window): everything reads zero
		if (w.bank < c.bank_first || w.bank > c.bank_last ||
				w.page < c.page_first || w.page > c.page_last)
			return r;
		r.hit = 1'b1;
		r.mem_kind = c.target_kind;
		if (span != 0) begin
			if (c.map_mode == cpmm_pkg::MODE_SHADOW) begin
				// full banks of 64 KiB, page inside the bank at 256 bytes each
				pos = 64'(c.start_offset) + (64'(w.bank) - 64'(c.bank_first)) * 64'd65536 +
					64'(w.page) * 64'd256;
			end else begin
				// pages counted one after another across the window
				per_bank = 64'(c.page_last) - 64'(c.page_first) + 64'd1;
				count = (64'(w.bank) - 64'(c.bank_first)) * per_bank +
					(64'(w.page) - 64'(c.page_first));
				pos = 64'(c.start_offset) + count * 64'd256;
			end
			pos = mirror_fold(span, pos % span);
			r.page_offset = pos[cpmm_pkg::OFFSET_W-1:0];
		end
		return r;
	endfunction

	function automatic void add_word(logic [7:0] bank, logic [7:0] page, logic typed,
			cpmm_pkg::out_word_t map);
		dir_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.word.bank = bank;
		r.word.page = page;
		r.typed = typed;
		r.map = map;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_reg(cpmm_pkg::reg_idx_t idx, logic [31:0] value);
		dir_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.value = value;
		dir_rows.push_back(r);
	endfunction

	// apb write: setup cycle, then access cycle until pready
	task automatic set_reg(cpmm_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			cpmm_pkg::REG_MAP_MODE:     window_cfg.map_mode = value[0];
			cpmm_pkg::REG_BANK_FIRST:   window_cfg.bank_first = value[7:0];
			cpmm_pkg::REG_BANK_LAST:    window_cfg.bank_last = value[7:0];
			cpmm_pkg::REG_PAGE_FIRST:   window_cfg.page_first = value[7:0];
			cpmm_pkg::REG_PAGE_LAST:    window_cfg.page_last = value[7:0];
			cpmm_pkg::REG_TARGET_KIND:  window_cfg.target_kind = value[0];
			cpmm_pkg::REG_START_OFFSET: window_cfg.start_offset = value[23:0];
			cpmm_pkg::REG_TARGET_SIZE:  window_cfg.target_size = value[24:0];
			default: ;
		endcase
	endtask

	// stop sending and wait until every expected mapping has come back
	task automatic drain_words();
		in_valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one word, with an optional gap before it, and log its expected mapping
	task automatic send_word(cpmm_pkg::in_word_t w, cpmm_pkg::out_word_t map);
		int unsigned gap;
		pending_map_t p;
		if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (in_stall);
		p.word = w;
		p.map = map;
		expected_maps.push_back(p);
	endtask

	// random window setting, every register written, extremes weighted in
	task automatic random_window();
		logic [7:0] bf;
		logic [7:0] bl;
		logic [7:0] pf;
		logic [7:0] pl;
		logic [31:0] start;
		logic [31:0] span;
		bf = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: begin
				bf = 8'h00;
				bl = 8'hff;
			end
			1: begin
				// empty bank range
				if (bf == 0)
					bf = 8'h01;
				bl = 8'($urandom_range(0, bf - 1));
			end
			2, 3: bl = 8'($urandom_range(bf, (bf > 239) ? 255 : bf + 16));
			default: bl = 8'($urandom_range(bf, 255));
		endcase
		pf = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: begin
				pf = 8'h00;
				pl = 8'hff;
			end
			1: begin
				if (pf == 0)
					pf = 8'h01;
				pl = 8'($urandom_range(0, pf - 1));
			end
			default: pl = 8'($urandom_range(pf, 255));
		endcase
		case ($urandom_range(0, 3))
			0: start = 32'h0;
			1: start = 32'hff_ffff;
			default: start = $urandom_range(0, 32'hff_ffff);
		endcase
		case ($urandom_range(0, 9))
			0: span = 32'h0;
			1: span = 32'h1;
			2: span = 32'h100_0000;
			3: span = $urandom_range(32'h100_0001, 32'h1ff_ffff);
			4: span = 32'hff_ffff;
			5: span = 32'h1 << $urandom_range(0, 23);
			6: span = $urandom_range(2, 255);
			default: span = $urandom_range(1, 32'h100_0000);
		endcase
		set_reg(cpmm_pkg::REG_MAP_MODE, $urandom_range(0, 1));
		set_reg(cpmm_pkg::REG_BANK_FIRST, 32'(bf));
		set_reg(cpmm_pkg::REG_BANK_LAST, 32'(bl));
		set_reg(cpmm_pkg::REG_PAGE_FIRST, 32'(pf));
		set_reg(cpmm_pkg::REG_PAGE_LAST, 32'(pl));
		set_reg(cpmm_pkg::REG_TARGET_KIND, $urandom_range(0, 1));
		set_reg(cpmm_pkg::REG_START_OFFSET, start);
		set_reg(cpmm_pkg::REG_TARGET_SIZE, span);
	endtask

	// mostly words inside the window, the rest anywhere on the bus
	function automatic cpmm_pkg::in_word_t pick_word();
		cpmm_pkg::in_word_t w;
		w.bank = 8'($urandom_range(0, 255));
		w.page = 8'($urandom_range(0, 255));
		if (window_cfg.bank_first <= window_cfg.bank_last &&
				window_cfg.page_first <= window_cfg.page_last && $urandom_range(0, 4) != 0) begin
			w.bank = 8'($urandom_range(window_cfg.bank_first, window_cfg.bank_last));
			w.page = 8'($urandom_range(window_cfg.page_first, window_cfg.page_last));
		end
		return w;
	endfunction

	// result side: check each accepted word, then decide the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (expected_maps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result word %0d: hit=%0b kind=%0b offset=%06h",
						result_count, out_data.hit, out_data.mem_kind, out_data.page_offset);
			end else begin
				head = expected_maps.pop_front();
				if (out_data.hit !== head.map.hit || out_data.mem_kind !== head.map.mem_kind ||
						out_data.page_offset !== head.map.page_offset) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"result word %0d (bank %02h page %02h): expected hit=%0b ",
							"kind=%0b offset=%06h, got hit=%0b kind=%0b offset=%06h"},
							result_count, head.word.bank, head.word.page, head.map.hit,
							head.map.mem_kind, head.map.page_offset, out_data.hit,
							out_data.mem_kind, out_data.page_offset);
				end
			end
		end
		// random stall bursts, counted down in stall_left
		if (stall_left > 0) begin
			stall_left--;
		end else if (!quiet_tail && !sink_calm && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// run limit, far above the slowest passing run
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned words;
		// register values after reset
		window_cfg = '0;
		window_cfg.page_last = 8'hff;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset window: bank 0 only, all pages, zero target size
		add_word(8'h00, 8'h00, 1'b1, ROM_ZERO);
		add_word(8'h01, 8'h00, 1'b1, MISS_WORD);
		add_word(8'h00, 8'hff, 1'b1, ROM_ZERO);
		// whole bus, linear, exactly 16 MiB of ROM: last page lands at the top
		add_reg(cpmm_pkg::REG_BANK_LAST, 32'hff);
		add_reg(cpmm_pkg::REG_TARGET_SIZE, 32'h100_0000);
		add_word(8'hff, 8'hff, 1'b1, {1'b1, 1'b0, 24'hffff00});
		add_word(8'h00, 8'h00, 1'b1, ROM_ZERO);
		add_word(8'h80, 8'h07, 1'b0, MISS_WORD);
		// shadow mode into save ram, largest start, oversized target clamps to 16 MiB
		add_reg(cpmm_pkg::REG_TARGET_KIND, 32'h1);
		add_reg(cpmm_pkg::REG_START_OFFSET, 32'hff_ffff);
		add_reg(cpmm_pkg::REG_MAP_MODE, 32'(cpmm_pkg::MODE_SHADOW));
		add_reg(cpmm_pkg::REG_TARGET_SIZE, 32'h1ff_ffff);
		add_word(8'hff, 8'hff, 1'b1, {1'b1, 1'b1, 24'hfffeff});
		add_word(8'h00, 8'h00, 1'b1, {1'b1, 1'b1, 24'hffffff});
		// tiny and odd target sizes exercise the wrap and the mirror fold
		add_reg(cpmm_pkg::REG_TARGET_SIZE, 32'h3);
		add_word(8'h03, 8'h55, 1'b0, MISS_WORD);
		add_word(8'haa, 8'haa, 1'b0, MISS_WORD);
		add_reg(cpmm_pkg::REG_TARGET_SIZE, 32'h12_3457);
		add_word(8'h5a, 8'ha5, 1'b0, MISS_WORD);
		// bounded linear window: both corners inside, one step past each edge outside
		add_reg(cpmm_pkg::REG_MAP_MODE, 32'(cpmm_pkg::MODE_LINEAR));
		add_reg(cpmm_pkg::REG_BANK_FIRST, 32'h20);
		add_reg(cpmm_pkg::REG_BANK_LAST, 32'h3f);
		add_reg(cpmm_pkg::REG_PAGE_FIRST, 32'h10);
		add_reg(cpmm_pkg::REG_PAGE_LAST, 32'h2f);
		add_word(8'h20, 8'h10, 1'b0, MISS_WORD);
		add_word(8'h3f, 8'h2f, 1'b0, MISS_WORD);
		add_word(8'h1f, 8'h10, 1'b1, MISS_WORD);
		add_word(8'h40, 8'h10, 1'b1, MISS_WORD);
		add_word(8'h20, 8'h0f, 1'b1, MISS_WORD);
		add_word(8'h20, 8'h30, 1'b1, MISS_WORD);
		// empty page range, then empty bank range
		add_reg(cpmm_pkg::REG_PAGE_FIRST, 32'h80);
		add_reg(cpmm_pkg::REG_PAGE_LAST, 32'h7f);
		add_word(8'h30, 8'h80, 1'b1, MISS_WORD);
		add_reg(cpmm_pkg::REG_PAGE_FIRST, 32'h00);
		add_reg(cpmm_pkg::REG_PAGE_LAST, 32'hff);
		add_reg(cpmm_pkg::REG_BANK_FIRST, 32'h90);
		add_reg(cpmm_pkg::REG_BANK_LAST, 32'h8f);
		add_word(8'h90, 8'h00, 1'b1, MISS_WORD);
		// one-byte target: every hit folds to offset zero
		add_reg(cpmm_pkg::REG_BANK_FIRST, 32'h00);
		add_reg(cpmm_pkg::REG_BANK_LAST, 32'h00);
		add_reg(cpmm_pkg::REG_TARGET_SIZE, 32'h1);
		add_word(8'h00, 8'hc3, 1'b0, MISS_WORD);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain_words();
				set_reg(dir_rows[i].idx, dir_rows[i].value);
			end else begin
				send_word(dir_rows[i].word, dir_rows[i].typed ? dir_rows[i].map :
					map_page(window_cfg, dir_rows[i].word));
			end
		end

		// random phases, each under a fresh window setting
		for (int ph = 0; ph <= PHASES; ph++) begin
			drain_words();
			random_window();
			sender_calm <= ($urandom_range(0, 3) == 0);
			sink_calm <= ($urandom_range(0, 3) == 0);
			// the last phase runs with no idling at all
			if (ph == PHASES)
				quiet_tail <= 1'b1;
			words = (ph == PHASES) ? TAIL_WORDS : $urandom_range(60, 100);
			for (int n = 0; n < words; n++) begin
				// hold the sender off mid-phase until the unit has emptied
				if (ph == 3 && n == words / 2)
					drain_words();
				begin
					cpmm_pkg::in_word_t w;
					w = pick_word();
					send_word(w, map_page(window_cfg, w));
				end
			end
		end

		in_valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		// catch any stray extra result words
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_maps.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/cpmm_pkg.sv
rtl/core/cpmm_regs.sv
rtl/core/cpmm_rem_unit.sv
rtl/core/cartridge_page_mirror_map_unit.sv
rtl/core/cpmm_checker.sv
dv/tb.sv
